// File: rtl/apm_pkg.sv
// Shared types, constants and command codes of the audio peak meter.
`timescale 1ns / 1ps
`default_nettype none
package apm_pkg;

  // Default log resolution (fraction bits of log2)
  localparam int LOG_TABLE_BITS_DEF = 6;
  // Position width of the result beat
  localparam int POS_BITS = 10;

  // Levels in Q8.8 dB
  localparam int LEVEL_FLOOR   = -30720;
  localparam int LEVEL_CEIL    = 1536;
  localparam int SILENCE_LEVEL = -17920;
  // 20*log10(2) in Q16
  localparam int DB_PER_OCTAVE = 394566;
  localparam int SCALE_ENTRIES = 381;
  localparam int SCALE_FULL    = 2300;
  // floor(2^24 / 2300) for the position quotient estimate
  localparam int SCALE_RECIP   = 7294;
  localparam int SCALE_SHIFT   = 24;
  // ceil(2^16 / 5) for the hold drop of 1.2 times the fall step
  localparam int FIFTH_RECIP   = 13108;

  // Register indexes
  localparam logic [1:0] REG_FALLOFF_STEP = 2'd0;
  localparam logic [1:0] REG_HOLD_TICKS   = 2'd1;
  localparam logic [1:0] REG_OVER_TICKS   = 2'd2;
  localparam logic [1:0] REG_METER_HEIGHT = 2'd3;

  // Register reset values
  localparam logic [9:0] FALLOFF_STEP_RST = 10'd120;
  localparam logic [7:0] HOLD_TICKS_RST   = 8'd25;
  localparam logic [3:0] OVER_TICKS_RST   = 4'd2;
  localparam logic [9:0] METER_HEIGHT_RST = 10'd200;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_NORM,
    OP_SQUARE,
    OP_SCALE,
    OP_APPLY,
    OP_MAP,
    OP_DIV,
    OP_FIX,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel;   // 0: level bar, 1: hold line
  } dp_cmd_t;

  typedef struct packed {
    logic skip;      // reset beat or silence: no level conversion
    logic out_busy;  // result register still full
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/audio_peak_meter_ballistics_top.sv
// Top level of the audio peak meter: sequencer plus datapath.
// An update beat runs load, normalize, LOG_TABLE_BITS squaring passes, scale, apply,
// then map, divide and fix for the bar and again for the hold line, then emit; a reset
// or silence beat skips normalize, squaring and scale. One beat is taken at a time; the
// squaring loop (one pass a cycle) and the shared position divider set the spacing of beats.
// Reset (rst_n low, synchronous) clears the meter state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module audio_peak_meter_ballistics_top #(
  parameter int LOG_TABLE_BITS = apm_pkg::LOG_TABLE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_kind,
  input  wire  [15:0]                  in_peak,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [apm_pkg::POS_BITS-1:0] out_meter_pos,
  output logic [apm_pkg::POS_BITS-1:0] out_hold_pos,
  output logic                         out_over_led,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [9:0]                   cfg_data
);

  apm_pkg::dp_cmd_t    cmd;
  apm_pkg::dp_status_t status;

  apm_ctrl #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  apm_dp #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_kind       (in_kind),
    .in_peak       (in_peak),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_meter_pos (out_meter_pos),
    .out_hold_pos  (out_hold_pos),
    .out_over_led  (out_over_led)
  );

  // One beat in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

endmodule
`default_nettype wire

// File: rtl/apm_dp.sv
// Datapath of the audio peak meter: log conversion, ballistics, pixel mapping.
`timescale 1ns / 1ps
`default_nettype none
module apm_dp #(
  parameter int LOG_TABLE_BITS = apm_pkg::LOG_TABLE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire apm_pkg::dp_cmd_t        cmd,
  output apm_pkg::dp_status_t          status,
  input  wire                          in_kind,
  input  wire  [15:0]                  in_peak,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [9:0]                   cfg_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [apm_pkg::POS_BITS-1:0] out_meter_pos,
  output logic [apm_pkg::POS_BITS-1:0] out_hold_pos,
  output logic                         out_over_led
);

  localparam int LgW   = LOG_TABLE_BITS + 5;
  localparam int ProdW = LgW + 20;
  localparam int Sh    = LOG_TABLE_BITS + 8;
  localparam int DbW   = ProdW - Sh;
  localparam int PW    = apm_pkg::POS_BITS;
  localparam int SCALE_HI = apm_pkg::SCALE_SHIFT + PW - 1;

  // Configuration
  logic [9:0] falloff_step_r;
  logic [7:0] hold_ticks_r;
  logic [3:0] over_ticks_r;
  logic [9:0] meter_height_r;

  // Beat and conversion registers
  logic                      kind_r;
  logic [15:0]               peak_r;
  logic [3:0]                e_r;
  logic [15:0]               m_r;
  logic [LOG_TABLE_BITS-1:0] frac_r;
  logic signed [16:0]        db_r;

  // Meter state
  logic signed [15:0] tail_r;
  logic signed [16:0] hold_r;
  logic               falling_r;
  logic [7:0]         timer_r;
  logic [3:0]         run_r;
  logic               lamp_r;

  // Position unit
  logic          bottom_r;
  logic [21:0]   x_r;
  logic [PW-1:0] qe_r;
  logic [PW-1:0] pos_t_r;
  logic [PW-1:0] pos_h_r;

  logic          out_valid_r;
  logic [PW-1:0] out_meter_r;
  logic [PW-1:0] out_hold_r;
  logic          out_over_r;

  // Status toward the controller
  logic silence;
  assign silence = (peak_r == 16'd0) &&
                   (tail_r <= 16'(apm_pkg::SILENCE_LEVEL));
  assign status.skip     = kind_r || silence;
  assign status.out_busy = out_valid_r && !out_ready;

  // Normalize: find the top set bit
  logic [3:0]  e_nxt;
  logic [15:0] m_nxt;
  always_comb begin
    e_nxt = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (peak_r[i]) begin
        e_nxt = 4'(i);
      end
    end
    m_nxt = peak_r << (4'd15 - e_nxt);
  end

  // Square the mantissa, one fraction bit per pass
  logic [31:0] sq;
  assign sq = m_r * m_r;

  // Scale log2 to dB and clamp
  logic signed [LgW-1:0]   lg;
  logic signed [ProdW-1:0] prod;
  logic signed [DbW-1:0]   db_sh;
  logic signed [16:0]      db_nxt;
  always_comb begin
    lg    = $signed({1'b0, e_r, frac_r}) - $signed(LgW'(15 << LOG_TABLE_BITS));
    prod  = ProdW'(lg) * $signed(ProdW'(apm_pkg::DB_PER_OCTAVE));
    db_sh = DbW'(prod >>> Sh);
    if (peak_r == 16'd0 || db_sh < DbW'(apm_pkg::LEVEL_FLOOR)) begin
      db_nxt = 17'(apm_pkg::LEVEL_FLOOR);
    end else if (db_sh > DbW'(apm_pkg::LEVEL_CEIL)) begin
      db_nxt = 17'(apm_pkg::LEVEL_CEIL);
    end else begin
      db_nxt = 17'(db_sh);
    end
  end

  // Ballistics for an update beat
  logic signed [16:0] step_s;
  logic [26:0]        drop_prod;
  logic signed [16:0] drop_s;
  logic signed [16:0] lvl;
  logic signed [16:0] hold1;
  logic [7:0]         timer_inc;
  logic [3:0]         run_inc;
  logic [3:0]         need;
  always_comb begin
    step_s    = $signed({7'd0, falloff_step_r});
    drop_prod = (27'({falloff_step_r, 2'b00}) + 27'({falloff_step_r, 1'b0})) *
                27'(apm_pkg::FIFTH_RECIP);
    drop_s    = $signed({6'd0, drop_prod[26:16]});
    if (17'(tail_r) - db_r > step_s) begin
      lvl = 17'(tail_r) - step_s;
    end else begin
      lvl = db_r;
    end
    if (falling_r && hold_r >= 17'(apm_pkg::LEVEL_FLOOR)) begin
      hold1 = hold_r - drop_s;
    end else begin
      hold1 = hold_r;
    end
    timer_inc = (timer_r == 8'd255) ? timer_r : timer_r + 8'd1;
    if (peak_r[15]) begin
      run_inc = (run_r == 4'd15) ? run_r : run_r + 4'd1;
    end else begin
      run_inc = 4'd0;
    end
    need = (over_ticks_r == 4'd0) ? 4'd1 : over_ticks_r;
  end

  // Map a level to its scale value
  logic signed [16:0] lvl_sel;
  logic [16:0]        span;
  logic [18:0]        span5;
  logic [10:0]        idx;
  logic signed [11:0] t;
  logic signed [12:0] ts;
  logic signed [12:0] s;
  logic               below;
  logic [21:0]        x_nxt;
  always_comb begin
    lvl_sel = cmd.sel ? hold_r : 17'(tail_r);
    span    = 17'(17'(apm_pkg::LEVEL_CEIL) - lvl_sel);
    span5   = {span, 2'b00} + 19'(span);
    idx     = span5[18:8];
    t       = 12'sd60 - $signed({idx[9:0], 1'b0});
    ts      = 13'(t);
    priority if (ts >= -13'sd200) begin
      s = 13'sd2000 + 13'sd5 * ts;
    end else if (ts >= -13'sd300) begin
      s = 13'sd1000 + 13'sd4 * (ts + 13'sd200);
    end else if (ts >= -13'sd400) begin
      s = 13'sd600 + 13'sd3 * (ts + 13'sd300);
    end else if (ts >= -13'sd500) begin
      s = 13'sd300 + ((13'sd3 * (ts + 13'sd400)) >>> 1);
    end else begin
      s = 13'sd150 + (ts + 13'sd500);
    end
    below = (idx >= 11'(apm_pkg::SCALE_ENTRIES)) || (s <= 13'sd0);
    x_nxt = 22'(s[11:0]) * 22'(meter_height_r);
  end

  // Quotient by the full scale: estimate, then one correction
  logic [34:0]   qprod;
  logic [22:0]   rem;
  logic [PW-1:0] q;
  logic [PW-1:0] pos_nxt;
  always_comb begin
    qprod = 35'(x_r) * 35'(apm_pkg::SCALE_RECIP);
    rem   = 23'(x_r) - 23'(qe_r) * 23'(apm_pkg::SCALE_FULL);
    q     = (rem >= 23'(apm_pkg::SCALE_FULL)) ? qe_r + PW'(1) : qe_r;
    pos_nxt = bottom_r ? PW'(meter_height_r) : PW'(meter_height_r) - q;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      falloff_step_r <= apm_pkg::FALLOFF_STEP_RST;
      hold_ticks_r   <= apm_pkg::HOLD_TICKS_RST;
      over_ticks_r   <= apm_pkg::OVER_TICKS_RST;
      meter_height_r <= apm_pkg::METER_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apm_pkg::REG_FALLOFF_STEP: falloff_step_r <= cfg_data;
        apm_pkg::REG_HOLD_TICKS:   hold_ticks_r   <= cfg_data[7:0];
        apm_pkg::REG_OVER_TICKS:   over_ticks_r   <= cfg_data[3:0];
        apm_pkg::REG_METER_HEIGHT: meter_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Meter state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r      <= 16'(apm_pkg::LEVEL_FLOOR);
      hold_r      <= 17'(apm_pkg::LEVEL_FLOOR);
      falling_r   <= 1'b0;
      timer_r     <= 8'd0;
      run_r       <= 4'd0;
      lamp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == apm_pkg::OP_APPLY) begin
        if (kind_r) begin
          tail_r    <= 16'(apm_pkg::LEVEL_FLOOR);
          hold_r    <= 17'(apm_pkg::LEVEL_FLOOR);
          falling_r <= 1'b0;
          timer_r   <= 8'd0;
          run_r     <= 4'd0;
          lamp_r    <= 1'b0;
        end else if (silence) begin
          hold_r <= 17'(apm_pkg::LEVEL_FLOOR);
          lamp_r <= 1'b0;
        end else begin
          if (run_inc >= need) begin
            lamp_r <= 1'b1;
            run_r  <= 4'd0;
          end else begin
            run_r <= run_inc;
          end
          tail_r <= 16'(lvl);
          if (hold1 <= lvl) begin
            hold_r    <= lvl;
            falling_r <= 1'b0;
            timer_r   <= 8'd0;
          end else begin
            hold_r <= hold1;
            if (!falling_r) begin
              timer_r <= timer_inc;
              if (timer_inc >= hold_ticks_r) begin
                falling_r <= 1'b1;
              end
            end
          end
        end
      end
      if (cmd.op == apm_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      apm_pkg::OP_LOAD: begin
        kind_r <= in_kind;
        peak_r <= in_peak;
      end
      apm_pkg::OP_NORM: begin
        e_r    <= e_nxt;
        m_r    <= m_nxt;
        frac_r <= '0;
      end
      apm_pkg::OP_SQUARE: begin
        if (sq[31]) begin
          m_r    <= sq[31:16];
          frac_r <= {frac_r[LOG_TABLE_BITS-2:0], 1'b1};
        end else begin
          m_r    <= sq[30:15];
          frac_r <= {frac_r[LOG_TABLE_BITS-2:0], 1'b0};
        end
      end
      apm_pkg::OP_SCALE: db_r <= db_nxt;
      apm_pkg::OP_MAP: begin
        bottom_r <= below;
        x_r      <= x_nxt;
      end
      apm_pkg::OP_DIV: qe_r <= qprod[SCALE_HI:apm_pkg::SCALE_SHIFT];
      apm_pkg::OP_FIX: begin
        if (cmd.sel) begin
          pos_h_r <= pos_nxt;
        end else begin
          pos_t_r <= pos_nxt;
        end
      end
      apm_pkg::OP_EMIT: begin
        out_meter_r <= pos_t_r;
        out_hold_r  <= pos_h_r;
        out_over_r  <= lamp_r;
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_meter_pos = out_meter_r;
  assign out_hold_pos  = out_hold_r;
  assign out_over_led  = out_over_r;

  // The bar level never leaves the scale range
  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r >= 16'(apm_pkg::LEVEL_FLOOR) && tail_r <= 16'(apm_pkg::LEVEL_CEIL))
    else $error("bar level out of range");

  // A result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == apm_pkg::OP_EMIT |-> !(out_valid_r && !out_ready))
    else $error("result overwritten");

endmodule
`default_nettype wire

// File: rtl/apm_ctrl.sv
// Sequencer of the audio peak meter: steps the datapath through one beat.
`timescale 1ns / 1ps
`default_nettype none
module apm_ctrl #(
  parameter int LOG_TABLE_BITS = apm_pkg::LOG_TABLE_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  output apm_pkg::dp_cmd_t        cmd,
  input  wire apm_pkg::dp_status_t status
);

  localparam int CntW = $clog2(LOG_TABLE_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQ, S_SCALE, S_APPLY, S_MAP, S_DIV, S_FIX, S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic            sel_r, sel_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    cmd.op    = apm_pkg::OP_NONE;
    cmd.sel   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = apm_pkg::OP_LOAD;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        cnt_nxt = '0;
        if (status.skip) begin
          state_nxt = S_APPLY;
        end else begin
          cmd.op    = apm_pkg::OP_NORM;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op  = apm_pkg::OP_SQUARE;
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_r == CntW'(LOG_TABLE_BITS - 1)) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.op    = apm_pkg::OP_SCALE;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.op    = apm_pkg::OP_APPLY;
        sel_nxt   = 1'b0;
        state_nxt = S_MAP;
      end
      S_MAP: begin
        cmd.op    = apm_pkg::OP_MAP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op    = apm_pkg::OP_DIV;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.op = apm_pkg::OP_FIX;
        if (sel_r) begin
          state_nxt = S_EMIT;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = S_MAP;
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.op    = apm_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Squaring passes stop at the fraction width
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQ |-> cnt_r <= CntW'(LOG_TABLE_BITS - 1))
    else $error("squaring count overrun");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench of the audio peak meter ballistics block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PW             = apm_pkg::POS_BITS;
  localparam int LTB            = apm_pkg::LOG_TABLE_BITS_DEF;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_kind = 1'b0;
  logic [15:0] in_peak = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [PW-1:0] out_meter_pos;
  logic [PW-1:0] out_hold_pos;
  logic       out_over_led;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = apm_pkg::REG_FALLOFF_STEP;
  logic [9:0] cfg_data = '0;

  audio_peak_meter_ballistics_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_peak(in_peak),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_meter_pos(out_meter_pos), .out_hold_pos(out_hold_pos),
    .out_over_led(out_over_led),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [PW-1:0] meter_pos;
    logic [PW-1:0] hold_pos;
    logic          over_led;
  } meter_view_t;

  // Meter model state and registers
  int unsigned fall_step, hold_time, over_need_cfg, height;
  int          bar_level, peak_hold;
  bit          hold_drop;
  int unsigned hold_count, full_run;
  bit          lamp_lit;

  meter_view_t view_q[$];
  int          error_count;
  int          send_idle_pct, recv_stall_pct;
  bit          recv_hold_off;
  int          quiet_cycles;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic int peak_to_db(input logic [15:0] pk);
    int unsigned top, mant, frac;
    longint      prod, mag;
    int          lg, db;
    if (pk == 0) return apm_pkg::LEVEL_FLOOR;
    top = 15;
    while (pk[top] == 1'b0) top--;
    mant = 32'(pk) << (15 - top);
    frac = 0;
    for (int k = 0; k < LTB; k++) begin
      mant = int'((longint'(mant) * mant) >> 15);
      frac = frac << 1;
      if (mant >= 65536) begin
        frac |= 1;
        mant = mant >> 1;
      end
    end
    lg = (int'(top) - 15) * (1 << LTB) + int'(frac);
    prod = longint'(lg) * apm_pkg::DB_PER_OCTAVE;
    if (prod >= 0) db = int'(prod >>> (LTB + 8));
    else begin
      mag = -prod;
      db = -int'((mag + (64'd1 << (LTB + 8)) - 1) >> (LTB + 8));
    end
    if (db < apm_pkg::LEVEL_FLOOR) db = apm_pkg::LEVEL_FLOOR;
    if (db > apm_pkg::LEVEL_CEIL) db = apm_pkg::LEVEL_CEIL;
    return db;
  endfunction

  function automatic logic [PW-1:0] db_to_pixel(input int lv);
    int unsigned idx, pos;
    int          t, s;
    if (lv > apm_pkg::LEVEL_CEIL) lv = apm_pkg::LEVEL_CEIL;
    idx = (5 * (apm_pkg::LEVEL_CEIL - lv)) >> 8;
    if (idx >= apm_pkg::SCALE_ENTRIES) return PW'(height);
    t = 60 - 2 * int'(idx);
    if (t >= -200)      s = 2000 + 5 * t;
    else if (t >= -300) s = 1000 + 4 * (t + 200);
    else if (t >= -400) s = 600 + 3 * (t + 300);
    else if (t >= -500) s = 300 + (3 * (t + 400)) / 2;
    else                s = 150 + (t + 500);
    if (s >= 0) pos = height - (s * height) / 2300;
    else        pos = height + ((-s) * height) / 2300;
    if (pos > height) pos = height;
    return PW'(pos);
  endfunction

  function automatic void clear_meter();
    bar_level = apm_pkg::LEVEL_FLOOR;
    peak_hold = apm_pkg::LEVEL_FLOOR;
    hold_drop = 0;
    hold_count = 0;
    full_run = 0;
    lamp_lit = 0;
  endfunction

  // Advance the meter by one beat and return what it shows
  function automatic meter_view_t meter_update(input bit kind, input logic [15:0] pk);
    meter_view_t v;
    int          db;
    int unsigned need;
    if (kind) clear_meter();
    else if (pk == 0 && bar_level <= apm_pkg::SILENCE_LEVEL) begin
      peak_hold = apm_pkg::LEVEL_FLOOR;
      lamp_lit = 0;
    end else begin
      need = (over_need_cfg == 0) ? 1 : over_need_cfg;
      if (pk >= 16'h8000) begin
        if (full_run < 15) full_run++;
      end else full_run = 0;
      if (full_run >= need) begin
        lamp_lit = 1;
        full_run = 0;
      end
      db = peak_to_db(pk);
      if (bar_level - db > int'(fall_step)) db = bar_level - int'(fall_step);
      bar_level = db;
      if (hold_drop && peak_hold >= apm_pkg::LEVEL_FLOOR)
        peak_hold -= (int'(fall_step) * 6) / 5;
      if (peak_hold <= db) begin
        peak_hold = db;
        hold_drop = 0;
        hold_count = 0;
      end else if (!hold_drop) begin
        if (hold_count < 255) hold_count++;
        if (hold_count >= hold_time) hold_drop = 1;
      end
    end
    v.meter_pos = db_to_pixel(bar_level);
    v.hold_pos  = db_to_pixel(peak_hold);
    v.over_led  = lamp_lit;
    return v;
  endfunction

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    meter_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (view_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = view_q.pop_front();
        if (out_meter_pos !== want.meter_pos)
          report_mismatch("meter_pos", out_meter_pos, want.meter_pos);
        if (out_hold_pos !== want.hold_pos)
          report_mismatch("hold_pos", out_hold_pos, want.hold_pos);
        if (out_over_led !== want.over_led)
          report_mismatch("over_led", out_over_led, want.over_led);
      end
    end
  end

  // Receiver stalls at random, or holds off entirely when asked
  always @(posedge clk) begin
    if (recv_hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || recv_hold_off || !rst_n)
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("audio_peak_meter_ballistics_top test failed");
        $finish;
      end
    end
  end

  // Offer one beat and record its prediction at the accepting edge
  task automatic send_beat(input bit kind, input logic [15:0] pk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_peak  <= pk;
    // Ready only moves at rising edges, so look at it at the falling edge before
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    view_q = {view_q, meter_update(kind, pk)};
  endtask

  // Check a directed beat against a value typed in, besides the predictor
  task automatic send_fixed(input bit kind, input logic [15:0] pk, input int mpos, input int hpos,
                            input int led);
    meter_view_t v;
    send_beat(kind, pk);
    v = view_q[$];
    if (mpos >= 0 && v.meter_pos != mpos) report_mismatch("table meter_pos", v.meter_pos, mpos);
    if (hpos >= 0 && v.hold_pos != hpos) report_mismatch("table hold_pos", v.hold_pos, hpos);
    if (led >= 0 && v.over_led != led) report_mismatch("table over_led", v.over_led, led);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive one register write beat; the caller drops the enable
  task automatic drive_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[9:0];
    @(posedge clk);
  endtask

  task automatic write_all(input int unsigned fs, input int unsigned ht, input int unsigned ot,
                           input int unsigned mh);
    drive_reg(apm_pkg::REG_FALLOFF_STEP, fs);
    drive_reg(apm_pkg::REG_HOLD_TICKS, ht);
    drive_reg(apm_pkg::REG_OVER_TICKS, ot);
    drive_reg(apm_pkg::REG_METER_HEIGHT, mh);
    cfg_we <= 1'b0;
    fall_step     = fs & 32'h3ff;
    hold_time     = ht & 32'hff;
    over_need_cfg = ot & 32'hf;
    height        = mh & 32'h3ff;
  endtask

  function automatic logic [15:0] random_peak();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'(16'h8000 + $urandom_range(32767));
      2: return 16'($urandom_range(15) << $urandom_range(12));
      3: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(32767) >> $urandom_range(15));
    endcase
  endfunction

  // Directed table: kind, peak, expected meter, hold, lamp (-1 = predictor only)
  typedef struct {
    bit          kind;
    logic [15:0] pk;
    int          mpos, hpos, led;
  } table_row_t;

  table_row_t dir_rows[] = '{
    '{1'b0, 16'h0000, 200, 200, 0},
    '{1'b0, 16'hffff, -1, -1, 0},
    '{1'b0, 16'h8000, -1, -1, 1},
    '{1'b0, 16'h8000, -1, -1, 1},
    '{1'b0, 16'h7fff, -1, -1, 1},
    '{1'b0, 16'h0001, -1, -1, 1},
    '{1'b0, 16'h0000, -1, -1, -1},
    '{1'b0, 16'h4000, -1, -1, -1},
    '{1'b0, 16'h5555, -1, -1, -1},
    '{1'b0, 16'haaaa, -1, -1, -1},
    '{1'b0, 16'h0100, -1, -1, -1},
    '{1'b0, 16'h0002, -1, -1, -1},
    '{1'b1, 16'hffff, 200, 200, 0},
    '{1'b0, 16'h0000, 200, 200, 0},
    '{1'b0, 16'h0800, -1, -1, -1},
    '{1'b1, 16'h0000, 200, 200, 0}
  };

  task automatic random_run(input int count);
    int burst;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) send_beat(1'b1, 16'($urandom_range(65535)));
      else if ($urandom_range(9) == 0) begin
        // Run of full-scale beats to work the over lamp
        burst = $urandom_range(1, 16);
        for (int j = 0; j < burst; j++)
          send_beat(1'b0, 16'(16'h8000 + $urandom_range(32767)));
      end else if ($urandom_range(9) == 0) begin
        // Loud hit then decay to exercise the fall limit and the hold
        send_beat(1'b0, 16'($urandom_range(16'h4000, 16'hffff)));
        burst = $urandom_range(1, 40);
        for (int j = 0; j < burst; j++) send_beat(1'b0, 16'($urandom_range(63)));
      end else send_beat(1'b0, random_peak());
    end
  endtask

  initial begin
    int unsigned phase_sets [5][4];
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold_off = 0;
    fall_step = apm_pkg::FALLOFF_STEP_RST;
    hold_time = apm_pkg::HOLD_TICKS_RST;
    over_need_cfg = apm_pkg::OVER_TICKS_RST;
    height = apm_pkg::METER_HEIGHT_RST;
    clear_meter();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_fixed(dir_rows[i].kind, dir_rows[i].pk, dir_rows[i].mpos, dir_rows[i].hpos,
                 dir_rows[i].led);
    wait_drained();

    // Register sets: reset-like, extremes, zero cases and a random set
    phase_sets = '{'{120, 25, 2, 200}, '{1, 1, 1, 1023}, '{1023, 255, 15, 1},
                   '{0, 0, 0, 0}, '{$urandom_range(1, 1023), $urandom_range(1, 255),
                                    $urandom_range(1, 15), $urandom_range(1, 1023)}};
    for (int ph = 0; ph < 5; ph++) begin
      write_all(phase_sets[ph][0], phase_sets[ph][1], phase_sets[ph][2], phase_sets[ph][3]);
      send_beat(1'b1, 16'h0000);
      for (int mode = 0; mode < 4; mode++) begin
        send_idle_pct  = (mode == 1) ? 47 : (mode == 3) ? 34 : 0;
        recv_stall_pct = (mode == 2) ? 47 : (mode == 3) ? 34 : 0;
        random_run(14);
      end
      wait_drained();
    end

    // Long receiver hold-off while the sender keeps offering beats
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_all(apm_pkg::FALLOFF_STEP_RST, apm_pkg::HOLD_TICKS_RST, apm_pkg::OVER_TICKS_RST,
              apm_pkg::METER_HEIGHT_RST);
    recv_hold_off <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        recv_hold_off <= 1'b0;
      end
      random_run(20);
    join
    wait_drained();
    random_run(30);
    wait_drained();

    if (error_count == 0) $display("audio_peak_meter_ballistics_top test passed");
    else $display("audio_peak_meter_ballistics_top test failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: audio_peak_meter_ballistics_top.f
rtl/apm_pkg.sv
rtl/apm_dp.sv
rtl/apm_ctrl.sv
rtl/audio_peak_meter_ballistics_top.sv
tb/sv/tb_top.sv
